// ===== src/assert_macros.svh =====
// Assertion macros shared by the upscaler RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk_i.
`define S2X_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define S2X_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/s2xup_pkg.sv =====
// Shared types, constants and the EPX pixel function of the 2x upscaler.
// No dependencies; every module of the block imports it.
package s2xup_pkg;

  localparam int unsigned MaxWidthBytesDef = 512;
  localparam int unsigned MaxRowsDef       = 4096;
  localparam int unsigned QueueDepthDef    = 4;

  localparam int unsigned WidthRegW  = 10;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned RowOutW    = 12;
  localparam int unsigned ColOutW    = 9;
  localparam int unsigned OutDataW   = 56;

  localparam logic [WidthRegW-1:0]  WidthReset  = 10'd512;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd4096;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SEL_UP   = 2'd0,
    SEL_LEFT = 2'd1,
    SEL_SELF = 2'd2
  } res_sel_e;

  typedef struct packed {
    logic has_up;
    logic has_left;
    logic has_self;
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic c1_lt_w;
  } s2xup_flags_t;

  typedef struct packed {
    logic [RowOutW-1:0] row;
    logic [ColOutW-1:0] col;
    logic [7:0]         px;
    logic [7:0]         mid_c;
    logic [7:0]         mid_c1;
    logic [7:0]         above_c;
    logic [7:0]         prev_mid;
    logic [7:0]         prev_px;
    logic [7:0]         prev2_px;
    s2xup_flags_t       flags;
  } s2xup_desc_t;

  // One EPX pixel: {upper-left, upper-right, lower-left, lower-right}.
  function automatic logic [15:0] epx_pixel(input logic [3:0] e, input logic [3:0] b,
                                            input logic [3:0] d, input logic [3:0] f,
                                            input logic [3:0] h);
    logic [3:0] c0, c1, c2, c3;
    c0 = e;
    c1 = e;
    c2 = e;
    c3 = e;
    if ((b != h) && (d != f)) begin
      c0 = (d == b) ? d : e;
      c1 = (b == f) ? f : e;
      c2 = (d == h) ? d : e;
      c3 = (h == f) ? f : e;
    end
    return {c0, c1, c2, c3};
  endfunction

endpackage

// ===== src/s2xup_front.sv =====
// Front end: position counters, the two line stores and item classification.
// Depends on s2xup_pkg; feeds work descriptors to s2xup_queue.
module s2xup_front import s2xup_pkg::*; #(
  parameter int unsigned MAX_WIDTH_BYTES = MaxWidthBytesDef,
  parameter int unsigned MAX_ROWS        = MaxRowsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [WidthRegW-1:0]  width_i,
  input  logic [HeightRegW-1:0] height_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_data_i,
  input  logic                  push_ready_i,
  output logic                  push_o,
  output s2xup_desc_t           desc_o
);

  localparam int unsigned CW   = (MAX_WIDTH_BYTES > 1) ? $clog2(MAX_WIDTH_BYTES) : 1;
  localparam int unsigned CNTW = CW + 1;
  localparam int unsigned RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RNTW = RW + 1;

  logic [CNTW-1:0] col_q, col_d, w_eff, c_full;
  logic [RW-1:0]   row_q, row_d, r_cur;
  logic [RNTW-1:0] h_eff, r_inc;
  logic [CW-1:0]   c_idx, c_nxt;
  logic            accept, last_row, c_last;
  s2xup_flags_t    flags;

  logic            s1_valid_q, s1_valid_d;
  logic [CW-1:0]   s1_c_q;
  logic [RowOutW-1:0] s1_row_q;
  logic [ColOutW-1:0] s1_col_q;
  s2xup_flags_t    s1_flags_q;
  logic [7:0]      s1_px_q;
  logic            coll_c_q, coll_c1_q;
  logic [7:0]      byp_mid_q, byp_above_q;
  logic [7:0]      mid_rd0_q, mid_rd1_q, above_rd_q;
  logic [7:0]      mid_c, mid_c1, above_c;
  logic [7:0]      prev_px_q, prev2_px_q, prev_mid_q;
  logic            s1_any, s1_adv;

  logic [7:0] mid_mem   [MAX_WIDTH_BYTES];
  logic [7:0] above_mem [MAX_WIDTH_BYTES];

  // Clamp the configured frame size into the supported range.
  always_comb begin
    if (width_i == '0) begin
      w_eff = CNTW'(1);
    end else if (32'(width_i) > 32'(MAX_WIDTH_BYTES)) begin
      w_eff = CNTW'(MAX_WIDTH_BYTES);
    end else begin
      w_eff = CNTW'(width_i);
    end
    if (height_i == '0) begin
      h_eff = RNTW'(1);
    end else if (32'(height_i) > 32'(MAX_ROWS)) begin
      h_eff = RNTW'(MAX_ROWS);
    end else begin
      h_eff = RNTW'(height_i);
    end
  end

  // Position of the arriving byte; wrap column, then row.
  always_comb begin
    if (col_q >= w_eff) begin
      c_full = '0;
      r_inc  = RNTW'(row_q) + RNTW'(1);
    end else begin
      c_full = col_q;
      r_inc  = RNTW'(row_q);
    end
    r_cur    = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    c_idx    = c_full[CW-1:0];
    c_nxt    = c_idx + CW'(1);
    last_row = (RNTW'(r_cur) + RNTW'(1)) == h_eff;
    c_last   = (CNTW'(c_idx) + CNTW'(1)) == w_eff;

    flags.r_ge1    = r_cur != '0;
    flags.r_ge2    = r_cur > RW'(1);
    flags.c_ge1    = c_idx != '0;
    flags.c_ge2    = c_idx > CW'(1);
    flags.c1_lt_w  = (CNTW'(c_idx) + CNTW'(1)) < w_eff;
    flags.has_up   = flags.r_ge1;
    flags.has_left = last_row && flags.c_ge1;
    flags.has_self = last_row && c_last;
  end

  // Stage 1 holds the item while its line store reads come back.
  assign s1_any     = s1_flags_q.has_up | s1_flags_q.has_left | s1_flags_q.has_self;
  assign s1_adv     = s1_valid_q && (!s1_any || push_ready_i);
  assign push_o     = s1_valid_q && s1_any && push_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign col_d      = accept ? (CNTW'(c_idx) + CNTW'(1)) : col_q;
  assign row_d      = accept ? r_cur : row_q;
  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  // Forward the write of the item ahead when it hits the same entry.
  assign mid_c   = coll_c_q  ? byp_mid_q   : mid_rd0_q;
  assign mid_c1  = coll_c1_q ? byp_mid_q   : mid_rd1_q;
  assign above_c = coll_c_q  ? byp_above_q : above_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_c_q      <= c_idx;
      s1_row_q    <= RowOutW'(r_cur);
      s1_col_q    <= ColOutW'(c_idx);
      s1_flags_q  <= flags;
      s1_px_q     <= in_data_i;
      coll_c_q    <= s1_adv && (s1_c_q == c_idx);
      coll_c1_q   <= s1_adv && (s1_c_q == c_nxt);
      byp_mid_q   <= s1_px_q;
      byp_above_q <= mid_c;
    end
    if (s1_adv) begin
      prev2_px_q <= prev_px_q;
      prev_px_q  <= s1_px_q;
      prev_mid_q <= mid_c;
    end
  end

  // Line stores: middle row and the row above it.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mid_mem[s1_c_q]   <= s1_px_q;
      above_mem[s1_c_q] <= mid_c;
    end
    if (accept) begin
      mid_rd0_q  <= mid_mem[c_idx];
      mid_rd1_q  <= mid_mem[c_nxt];
      above_rd_q <= above_mem[c_idx];
    end
  end

  always_comb begin
    desc_o.row      = s1_row_q;
    desc_o.col      = s1_col_q;
    desc_o.px       = s1_px_q;
    desc_o.mid_c    = mid_c;
    desc_o.mid_c1   = mid_c1;
    desc_o.above_c  = above_c;
    desc_o.prev_mid = prev_mid_q;
    desc_o.prev_px  = prev_px_q;
    desc_o.prev2_px = prev2_px_q;
    desc_o.flags    = s1_flags_q;
  end

endmodule

// ===== src/s2xup_queue.sv =====
// Short FIFO of work descriptors between front and back end.
// Depends on s2xup_pkg and assert_macros.svh.
`include "assert_macros.svh"
module s2xup_queue import s2xup_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  s2xup_desc_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output s2xup_desc_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  s2xup_desc_t   mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  `S2X_ASSERT(a_no_overflow, !(push_i && (cnt_q == CntW'(DEPTH))), "push into full queue")
  `S2X_ASSERT(a_no_underflow, !(pop_i && (cnt_q == '0)), "pop from empty queue")
  `S2X_ASSERT_NEXT(a_push_grows, push_i && !pop_i, cnt_q == $past(cnt_q) + CntW'(1), "count lost")

endmodule

// ===== src/s2xup_back.sv =====
// Back end: picks each pending result of the head descriptor, runs EPX
// and holds the result in the output register. Depends on s2xup_pkg.
module s2xup_back import s2xup_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  s2xup_desc_t         desc_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_last_o
);

  logic [1:0]   done_q, done_d;   // {up done, left done}
  logic         out_valid_q, out_valid_d;
  logic         load, sel_last;
  res_sel_e     sel;
  s2xup_flags_t fl;
  logic [7:0]   e, b, h;
  logic [3:0]   dn, fn;
  logic [RowOutW-1:0] row;
  logic [ColOutW-1:0] col;
  logic [15:0]  p0, p1;
  logic [15:0]  upper_q, lower_q;
  logic [RowOutW-1:0] row_q;
  logic [ColOutW-1:0] col_q;
  logic         last_q;

  assign fl = desc_i.flags;

  // Results go out in order: row above, left byte, this byte.
  always_comb begin
    if (fl.has_up && !done_q[1]) begin
      sel      = SEL_UP;
      sel_last = !fl.has_left && !fl.has_self;
    end else if (fl.has_left && !done_q[0]) begin
      sel      = SEL_LEFT;
      sel_last = !fl.has_self;
    end else begin
      sel      = SEL_SELF;
      sel_last = 1'b1;
    end
  end

  always_comb begin
    case (sel)
      SEL_UP: begin
        e   = desc_i.mid_c;
        b   = fl.r_ge2 ? desc_i.above_c : desc_i.mid_c;
        h   = desc_i.px;
        dn  = fl.c_ge1 ? desc_i.prev_mid[3:0] : desc_i.mid_c[7:4];
        fn  = fl.c1_lt_w ? desc_i.mid_c1[7:4] : desc_i.mid_c[3:0];
        row = desc_i.row - RowOutW'(1);
        col = desc_i.col;
      end
      SEL_LEFT: begin
        e   = desc_i.prev_px;
        b   = fl.r_ge1 ? desc_i.prev_mid : desc_i.prev_px;
        h   = desc_i.prev_px;
        dn  = fl.c_ge2 ? desc_i.prev2_px[3:0] : desc_i.prev_px[7:4];
        fn  = desc_i.px[7:4];
        row = desc_i.row;
        col = desc_i.col - ColOutW'(1);
      end
      default: begin
        e   = desc_i.px;
        b   = fl.r_ge1 ? desc_i.mid_c : desc_i.px;
        h   = desc_i.px;
        dn  = fl.c_ge1 ? desc_i.prev_px[3:0] : desc_i.px[7:4];
        fn  = desc_i.px[3:0];
        row = desc_i.row;
        col = desc_i.col;
      end
    endcase
    p0 = epx_pixel(e[7:4], b[7:4], dn, e[3:0], h[7:4]);
    p1 = epx_pixel(e[3:0], b[3:0], e[7:4], fn, h[3:0]);
  end

  assign load        = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o       = load && sel_last;
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_comb begin
    done_d = done_q;
    if (load) begin
      if (sel_last) begin
        done_d = '0;
      end else if (sel == SEL_UP) begin
        done_d[1] = 1'b1;
      end else begin
        done_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      upper_q <= {p0[15:8], p1[15:8]};
      lower_q <= {p0[7:0], p1[7:0]};
      row_q   <= row;
      col_q   <= col;
      last_q  <= sel_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_last_o  = last_q;
  assign out_data_o  = {3'b000, lower_q, upper_q, col_q, row_q};

endmodule

// ===== src/scale2x_packed_nibble_upscaler.sv =====
// Scale2x (EPX) upscaler for frames of packed 4-bit palette pixels.
// Usage:
//   s_axis carries one packed byte per beat (two pixels, left in the high
//   nibble) in raster order. Frame size comes from the APB registers
//   width_bytes (0x0) and height_rows (0x4); write them only while idle.
//   m_axis carries one upscaled source byte per beat: a 2x2 expansion of
//   both pixels, as upper and lower destination row nibbles, plus the
//   source row and column. tlast marks the final result of an input byte.
//   A byte of row r is emitted when the byte below it arrives; bytes of the
//   last row are emitted as that row streams in, so such an input gives up
//   to three results.
// Path: an input byte passes the stage 1 register, the queue write and
//   the output register load before its first result shows on m_axis.
// Throughput: one input byte per cycle while m_axis is ready and each byte
//   causes at most one result; on the last row the single output register
//   limits the stream to one result per cycle.
// Reset clears the position counters and the queue; line store contents
//   are not cleared. When m_axis stalls, the output register holds, the
//   four-entry descriptor queue fills, then s_axis drops tready.
// Depends on s2xup_pkg, s2xup_front, s2xup_queue, s2xup_back.
module scale2x_packed_nibble_upscaler import s2xup_pkg::*; #(
  parameter int unsigned MAX_WIDTH_BYTES = MaxWidthBytesDef,
  parameter int unsigned MAX_ROWS        = MaxRowsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] pixel_pair
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [11:0] out_row, [20:12] out_col, [36:21] upper_pixels,
  // [52:37] lower_pixels, [55:53] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,   // last_of_run
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [WidthRegW-1:0]  width_q, width_d;
  logic [HeightRegW-1:0] height_q, height_d;
  logic                  cfg_wr;
  cfg_reg_e              cfg_sel;

  logic        push, q_full, q_empty, pop;
  s2xup_desc_t push_desc, head_desc;

  // Register file: word-aligned, address bit 2 picks the register.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      case (cfg_sel)
        REG_WIDTH:  width_d  = pwdata[WidthRegW-1:0];
        REG_HEIGHT: height_d = pwdata[HeightRegW-1:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WIDTH:  prdata = {{(32 - WidthRegW){1'b0}}, width_q};
      REG_HEIGHT: prdata = {{(32 - HeightRegW){1'b0}}, height_q};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Front: count position, read and update line stores, classify.
  s2xup_front #(
    .MAX_WIDTH_BYTES (MAX_WIDTH_BYTES),
    .MAX_ROWS        (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .width_i      (width_q),
    .height_i     (height_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .push_ready_i (!q_full),
    .push_o       (push),
    .desc_o       (push_desc)
  );

  // Queue decouples the line store side from the output side.
  s2xup_queue #(
    .DEPTH (QueueDepthDef)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (head_desc)
  );

  // Back: expand each descriptor into its results.
  s2xup_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .desc_i      (head_desc),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
